// ----- design/cmap_pkg.sv -----
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared types and constants for the circular monochromatic progression
// detector.
// ----------------------------------------------------------------------------
package cmap_pkg;

  // Default board memory depth.
  localparam int MAX_CELLS_DEF = 256;

  // Fixed field widths.
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] BOARD_SIZE_RST = 9'd64;
  localparam logic [CFG_W-1:0] AP_LENGTH_RST  = 9'd3;

  // Register indexes, taken from address bit 2.
  localparam logic REG_BOARD_SIZE = 1'b0;
  localparam logic REG_AP_LENGTH  = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_EMPTY = '0;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_MEMBER = 2'd1,
    KIND_WINNER = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic               vld;
    logic               ap_found;
    logic [COLOR_W-1:0] winner_color;
  } res_t;

endpackage

// ----- design/cmap_board_ram.sv -----
// ----------------------------------------------------------------------------
// cmap_board_ram
// Board cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cmap_board_ram #(
  parameter int MAX_CELLS = cmap_pkg::MAX_CELLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_CELLS)-1:0] waddr_i,
  input  logic [cmap_pkg::COLOR_W-1:0] wdata_i,
  input  logic [$clog2(MAX_CELLS)-1:0] raddr_i,
  output logic [cmap_pkg::COLOR_W-1:0] rdata_o
);

  logic [cmap_pkg::COLOR_W-1:0] mem_q [MAX_CELLS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/cmap_step_unit.sv -----
// ----------------------------------------------------------------------------
// cmap_step_unit
// Shared arithmetic unit: moves a board position by a distance forward or backward
// modulo the board size and advances an offset accumulator against a limit.
// ----------------------------------------------------------------------------
module cmap_step_unit #(
  parameter int MAX_CELLS = cmap_pkg::MAX_CELLS_DEF,
  localparam int AW   = $clog2(MAX_CELLS),
  localparam int NW   = $clog2(MAX_CELLS + 1),
  localparam int CmpW = (NW > cmap_pkg::CFG_W) ? NW : cmap_pkg::CFG_W,
  localparam int AccW = CmpW + 1
) (
  input  logic [NW-1:0]   n_i,
  input  logic [NW-1:0]   lim_i,
  input  logic [AW-1:0]   pos_i,
  input  logic [NW-1:0]   dist_i,
  input  logic            back_i,
  input  logic [AccW-1:0] acc_i,
  input  logic [AccW-1:0] add_i,
  output logic [AW-1:0]   pos_o,
  output logic [AccW-1:0] acc_o,
  output logic            acc_le_o
);

  logic [NW:0] pos_e;
  logic [NW:0] dist_e;
  logic [NW:0] n_e;
  logic [NW:0] fwd_sum;
  logic [NW:0] pos_nx;

  assign pos_e   = (NW+1)'(pos_i);
  assign dist_e  = (NW+1)'(dist_i);
  assign n_e     = (NW+1)'(n_i);
  assign fwd_sum = pos_e + dist_e;

  // The distance is always below the board size, so one correction suffices.
  always_comb begin
    if (back_i) begin
      if (pos_e >= dist_e) begin
        pos_nx = pos_e - dist_e;
      end else begin
        pos_nx = pos_e + n_e - dist_e;
      end
    end else begin
      if (fwd_sum >= n_e) begin
        pos_nx = fwd_sum - n_e;
      end else begin
        pos_nx = fwd_sum;
      end
    end
  end

  assign pos_o    = pos_nx[AW-1:0];
  assign acc_o    = acc_i + add_i;
  assign acc_le_o = (acc_o <= AccW'(lim_i));

endmodule

// ----- design/cmap_seq.sv -----
// ----------------------------------------------------------------------------
// cmap_seq
// Sequencer: clears the board after reset, runs writes, membership checks and
// winner scans one board read at a time through the shared step unit.
// ----------------------------------------------------------------------------
module cmap_seq #(
  parameter int MAX_CELLS = cmap_pkg::MAX_CELLS_DEF,
  localparam int AW   = $clog2(MAX_CELLS),
  localparam int NW   = $clog2(MAX_CELLS + 1),
  localparam int CmpW = (NW > cmap_pkg::CFG_W) ? NW : cmap_pkg::CFG_W,
  localparam int AccW = CmpW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [cmap_pkg::IDX_W-1:0]   cell_index_i,
  input  logic [cmap_pkg::COLOR_W-1:0] cell_color_i,
  input  logic [cmap_pkg::CFG_W-1:0]   board_size_i,
  input  logic [cmap_pkg::CFG_W-1:0]   ap_length_i,
  input  logic                         out_free_i,
  output cmap_pkg::res_t               res_o,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic [cmap_pkg::COLOR_W-1:0] wdata_o,
  output logic [AW-1:0]                raddr_o,
  input  logic [cmap_pkg::COLOR_W-1:0] rdata_i
);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_WR,
    ST_M_LOAD, ST_M_C, ST_M_D, ST_M_BR, ST_M_BC, ST_M_FS, ST_M_FR, ST_M_FC, ST_M_NX,
    ST_W_I, ST_W_IC, ST_W_D, ST_W_R, ST_W_C, ST_W_NX,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                clr_q;
  logic [NW-1:0]                n_q;
  logic [cmap_pkg::CFG_W-1:0]   k_q;
  logic [cmap_pkg::CFG_W-1:0]   div_q;
  logic [AW-1:0]                loc_q;
  logic                         in_rng_q;
  logic [cmap_pkg::COLOR_W-1:0] color_q;
  logic [cmap_pkg::COLOR_W-1:0] c_q;
  logic [NW-1:0]                i_q;
  logic [NW-1:0]                d_q;
  logic [AccW-1:0]              dk_q;
  logic [AW-1:0]                pos_q;
  logic [AccW-1:0]              off_q;
  logic [AccW-1:0]              cnt_q;
  logic [cmap_pkg::CFG_W-1:0]   t_q;
  logic                         found_q;
  logic [cmap_pkg::COLOR_W-1:0] win_q;

  logic [CmpW-1:0]            bs_e;
  logic [CmpW-1:0]            max_e;
  logic [CmpW-1:0]            n_cur_e;
  logic                       idx_in;
  logic [cmap_pkg::CFG_W-1:0] div_cur;
  logic [NW-1:0]              nm1;
  logic                       k_le1;
  logic [AccW-1:0]            cnt_inc;
  logic                       cnt_hit;
  logic [cmap_pkg::CFG_W:0]   t_inc;
  logic                       t_hit;
  logic                       dk_ok;
  logic                       accept;
  logic                       same;

  logic [AW-1:0]   su_pos;
  logic            su_back;
  logic [AccW-1:0] su_acc;
  logic [AccW-1:0] su_add;
  logic [AW-1:0]   su_pos_nx;
  logic [AccW-1:0] su_acc_nx;
  logic            su_le;

  // Board size in use is clamped to the memory depth.
  assign bs_e    = CmpW'(board_size_i);
  assign max_e   = CmpW'(MAX_CELLS);
  assign n_cur_e = (bs_e > max_e) ? max_e : bs_e;
  assign idx_in  = (CmpW'(cell_index_i) < n_cur_e);
  assign div_cur = (ap_length_i > 9'd1) ? (ap_length_i - 9'd1) : 9'd1;

  assign nm1     = n_q - NW'(1);
  assign k_le1   = (k_q <= 9'd1);
  assign cnt_inc = cnt_q + AccW'(1);
  assign cnt_hit = (cnt_inc >= AccW'(k_q));
  assign t_inc   = (cmap_pkg::CFG_W+1)'(t_q) + (cmap_pkg::CFG_W+1)'(1);
  assign t_hit   = (t_inc >= (cmap_pkg::CFG_W+1)'(k_q));
  assign dk_ok   = (dk_q <= AccW'(nm1));
  assign same    = (rdata_i == c_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  assign res_o.vld          = (state_q == ST_DONE);
  assign res_o.ap_found     = found_q;
  assign res_o.winner_color = win_q;

  // Operand selection for the shared step unit.
  always_comb begin
    su_pos  = pos_q;
    su_back = 1'b0;
    su_acc  = off_q;
    su_add  = AccW'(d_q);
    unique case (state_q)
      ST_M_D: begin
        su_pos  = loc_q;
        su_back = 1'b1;
        su_acc  = '0;
      end
      ST_M_BC: begin
        su_back = 1'b1;
      end
      ST_M_FS: begin
        su_pos = loc_q;
        su_acc = '0;
      end
      ST_M_NX, ST_W_NX: begin
        su_acc = dk_q;
        su_add = AccW'(div_q);
      end
      ST_W_D: begin
        su_pos = AW'(i_q);
        su_acc = '0;
      end
      default: begin
      end
    endcase
  end

  cmap_step_unit #(
    .MAX_CELLS(MAX_CELLS)
  ) u_step (
    .n_i     (n_q),
    .lim_i   (nm1),
    .pos_i   (su_pos),
    .dist_i  (d_q),
    .back_i  (su_back),
    .acc_i   (su_acc),
    .add_i   (su_add),
    .pos_o   (su_pos_nx),
    .acc_o   (su_acc_nx),
    .acc_le_o(su_le)
  );

  // Memory port control.
  always_comb begin
    we_o    = 1'b0;
    waddr_o = loc_q;
    wdata_o = color_q;
    raddr_o = pos_q;
    unique case (state_q)
      ST_CLR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = cmap_pkg::COLOR_EMPTY;
      end
      ST_WR: begin
        we_o = in_rng_q;
      end
      ST_M_LOAD: begin
        raddr_o = loc_q;
      end
      ST_W_I: begin
        raddr_o = AW'(i_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      n_q      <= '0;
      k_q      <= '0;
      div_q    <= '0;
      loc_q    <= '0;
      in_rng_q <= 1'b0;
      color_q  <= '0;
      c_q      <= '0;
      i_q      <= '0;
      d_q      <= '0;
      dk_q     <= '0;
      pos_q    <= '0;
      off_q    <= '0;
      cnt_q    <= '0;
      t_q      <= '0;
      found_q  <= 1'b0;
      win_q    <= '0;
    end else begin
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            n_q      <= NW'(n_cur_e);
            k_q      <= ap_length_i;
            div_q    <= div_cur;
            loc_q    <= AW'(cell_index_i);
            in_rng_q <= idx_in;
            color_q  <= cell_color_i;
            i_q      <= '0;
            found_q  <= 1'b0;
            win_q    <= '0;
            unique case (cmap_pkg::kind_e'(kind_i))
              cmap_pkg::KIND_WRITE:  state_q <= ST_WR;
              cmap_pkg::KIND_MEMBER: state_q <= idx_in ? ST_M_LOAD : ST_DONE;
              cmap_pkg::KIND_WINNER: state_q <= ST_W_I;
              cmap_pkg::KIND_NONE:   state_q <= ST_DONE;
              default:               state_q <= ST_DONE;
            endcase
          end
        end
        ST_WR: begin
          state_q <= ST_DONE;
        end
        // Membership check.
        ST_M_LOAD: begin
          state_q <= ST_M_C;
        end
        ST_M_C: begin
          c_q     <= rdata_i;
          d_q     <= NW'(1);
          dk_q    <= AccW'(div_q);
          state_q <= ST_M_D;
        end
        ST_M_D: begin
          if (!dk_ok) begin
            state_q <= ST_DONE;
          end else if (k_le1) begin
            found_q <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= AccW'(1);
            pos_q   <= su_pos_nx;
            off_q   <= su_acc_nx;
            state_q <= ST_M_BR;
          end
        end
        ST_M_BR: begin
          state_q <= ST_M_BC;
        end
        ST_M_BC: begin
          if (!same) begin
            state_q <= ST_M_FS;
          end else if (cnt_hit) begin
            found_q <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_inc;
            if (su_le) begin
              pos_q   <= su_pos_nx;
              off_q   <= su_acc_nx;
              state_q <= ST_M_BR;
            end else begin
              state_q <= ST_M_FS;
            end
          end
        end
        ST_M_FS: begin
          pos_q   <= su_pos_nx;
          off_q   <= su_acc_nx;
          state_q <= ST_M_FR;
        end
        ST_M_FR: begin
          state_q <= ST_M_FC;
        end
        ST_M_FC: begin
          if (!same) begin
            state_q <= ST_M_NX;
          end else if (cnt_hit) begin
            found_q <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_inc;
            if (su_le) begin
              pos_q   <= su_pos_nx;
              off_q   <= su_acc_nx;
              state_q <= ST_M_FR;
            end else begin
              state_q <= ST_M_NX;
            end
          end
        end
        ST_M_NX: begin
          dk_q    <= su_acc_nx;
          d_q     <= d_q + NW'(1);
          state_q <= ST_M_D;
        end
        // Winner scan.
        ST_W_I: begin
          if (i_q < n_q) begin
            state_q <= ST_W_IC;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_W_IC: begin
          c_q <= rdata_i;
          if (rdata_i == cmap_pkg::COLOR_EMPTY) begin
            i_q     <= i_q + NW'(1);
            state_q <= ST_W_I;
          end else begin
            d_q     <= NW'(1);
            dk_q    <= AccW'(div_q);
            state_q <= ST_W_D;
          end
        end
        ST_W_D: begin
          if (!dk_ok) begin
            i_q     <= i_q + NW'(1);
            state_q <= ST_W_I;
          end else if (k_le1) begin
            win_q   <= c_q;
            state_q <= ST_DONE;
          end else begin
            t_q     <= 9'd1;
            pos_q   <= su_pos_nx;
            state_q <= ST_W_R;
          end
        end
        ST_W_R: begin
          state_q <= ST_W_C;
        end
        ST_W_C: begin
          if (!same) begin
            state_q <= ST_W_NX;
          end else if (t_hit) begin
            win_q   <= c_q;
            state_q <= ST_DONE;
          end else begin
            t_q     <= t_inc[cmap_pkg::CFG_W-1:0];
            pos_q   <= su_pos_nx;
            state_q <= ST_W_R;
          end
        end
        ST_W_NX: begin
          dk_q    <= su_acc_nx;
          d_q     <= d_q + NW'(1);
          state_q <= ST_W_D;
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/circular_mono_ap_detector.sv -----
// ----------------------------------------------------------------------------
// circular_mono_ap_detector
// Circular board of colored cells with membership checks and a winner scan
// for equal-colored arithmetic progressions.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   -------  ---------  -----------------------  ----------------------------------
//   input    in         in_valid_i / in_stall_o  kind_i, cell_index_i, cell_color_i
//   output   out        out_valid_o / out_stall_i  ap_found_o, winner_color_o
//   config   in/out     APB psel/penable/pready  paddr, pwdata, prdata
//
// After reset the board memory is cleared one cell a cycle while in_stall_o
// stays high; configuration writes are taken meanwhile. A membership check
// and a winner scan are limited by the single memory read port with its
// registered data: a check reads about 2*n/d cells for each step d, a scan
// up to n*dmax*(k-1) cells in the worst case. Only one request is in flight;
// a finished result sits in the output register, so a stalled output holds
// the result without stopping the next request from being accepted once the
// sequencer has handed it over.
//
module circular_mono_ap_detector #(
  parameter int MAX_CELLS = cmap_pkg::MAX_CELLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [cmap_pkg::IDX_W-1:0]   cell_index_i,
  input  logic [cmap_pkg::COLOR_W-1:0] cell_color_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ap_found_o,
  output logic [cmap_pkg::COLOR_W-1:0] winner_color_o,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW = $clog2(MAX_CELLS);

  logic [cmap_pkg::CFG_W-1:0]   board_size_q;
  logic [cmap_pkg::CFG_W-1:0]   ap_length_q;
  logic                         cfg_wr;

  logic                         out_valid_q;
  logic                         ap_found_q;
  logic [cmap_pkg::COLOR_W-1:0] winner_color_q;
  logic                         out_free;

  cmap_pkg::res_t               res;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [cmap_pkg::COLOR_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [cmap_pkg::COLOR_W-1:0] ram_rdata;

  // The register bank answers every access at once.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= cmap_pkg::BOARD_SIZE_RST;
      ap_length_q  <= cmap_pkg::AP_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cmap_pkg::REG_BOARD_SIZE: board_size_q <= pwdata[cmap_pkg::CFG_W-1:0];
        cmap_pkg::REG_AP_LENGTH:  ap_length_q  <= pwdata[cmap_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cmap_pkg::REG_BOARD_SIZE: prdata = 32'(board_size_q);
      cmap_pkg::REG_AP_LENGTH:  prdata = 32'(ap_length_q);
      default:                  prdata = '0;
    endcase
  end

  // The sequencer drives the board memory ports and holds the shared step unit. It holds
  // each finished result until the output register is free to take it.
  cmap_seq #(
    .MAX_CELLS(MAX_CELLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .cell_index_i(cell_index_i),
    .cell_color_i(cell_color_i),
    .board_size_i(board_size_q),
    .ap_length_i (ap_length_q),
    .out_free_i  (out_free),
    .res_o       (res),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata)
  );

  cmap_board_ram #(
    .MAX_CELLS(MAX_CELLS)
  ) u_board (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Output register: free when empty or when its result is taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      ap_found_q     <= 1'b0;
      winner_color_q <= '0;
    end else if (out_free) begin
      out_valid_q <= res.vld;
      if (res.vld) begin
        ap_found_q     <= res.ap_found;
        winner_color_q <= res.winner_color;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ap_found_o     = ap_found_q;
  assign winner_color_o = winner_color_q;

  // An accepted request always keeps the input side stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // A check answers only ap_found and a scan only winner_color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ap_found_o && (winner_color_o != cmap_pkg::COLOR_EMPTY)))
    else $error("result carries both a hit and a winner color");

  // A new result is loaded only while the sequencer holds the input stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

endmodule
